// File: rtl/wrp_pkg.sv
// shared types and constants for the weighted random pick block
package wrp_pkg;

  localparam int ENTRIES    = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WEIGHT_W   = 16;
  localparam int POOL_W     = 8;
  localparam int EFF_W      = WEIGHT_W + POOL_W;
  localparam int SUM_W      = EFF_W + IDX_W;
  localparam int RAND_W     = 16;
  localparam int PROD_W     = RAND_W + SUM_W;
  localparam int ACT_W      = 2;
  localparam int IN_IDX_W   = 6;
  localparam int OUT_IDX_W  = 6;
  localparam int OUT_TOT_W  = 30;
  localparam int NUSE_W     = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [WEIGHT_W-1:0] ONE_Q88 = WEIGHT_W'(256);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_PICK  = 2'd1,
    ACT_CLEAR = 2'd2
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_WEIGHT    = 3'd0,
    REG_USE_POOL      = 3'd1,
    REG_SCALE_BY_POOL = 3'd2,
    REG_ALLOW_REPEAT  = 3'd3,
    REG_ENTRIES       = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [POOL_W-1:0]   pool;
    logic                blocked;
  } entry_t;

  typedef struct packed {
    logic use_weight;
    logic use_pool;
    logic scale_by_pool;
    logic allow_repeat;
  } cfg_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    logic             mark_set;
    logic             mark_clr;
  } store_req_t;

  typedef struct packed {
    logic shift;
    logic acc_add;
    logic acc_clr;
    logic ld_total;
    logic ld_thr;
  } dp_ctl_t;

endpackage

// File: rtl/wrp_store.sv
// entry table memory with per-entry valid flags and picked marks
module wrp_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wrp_pkg::store_req_t  req,
  output wrp_pkg::entry_t      rd_ent,
  output logic                 rd_mark
);
  import wrp_pkg::*;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] marks_r;
  entry_t             rd_data_r;
  logic               rd_valid_r;
  logic               rd_mark_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data_r <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      marks_r    <= '0;
      rd_valid_r <= 1'b0;
      rd_mark_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.mark_clr) begin
        marks_r <= '0;
      end else if (req.mark_set) begin
        marks_r[req.wr_addr] <= 1'b1;
      end
      rd_valid_r <= valid_r[req.rd_addr];
      rd_mark_r  <= marks_r[req.rd_addr];
    end
  end

  assign rd_ent  = rd_valid_r ? rd_data_r : '0;
  assign rd_mark = rd_mark_r;

endmodule

// File: rtl/wrp_dp.sv
// effective weight stage, shared accumulator, target threshold and compare
module wrp_dp (
  input  logic                        clk,
  input  wrp_pkg::cfg_t               cfg,
  input  wrp_pkg::dp_ctl_t            ctl,
  input  wrp_pkg::entry_t             rd_ent,
  input  logic                        rd_mark,
  input  logic [wrp_pkg::RAND_W-1:0]  rand_val,
  output wrp_pkg::entry_t             stage_ent,
  output logic [wrp_pkg::SUM_W-1:0]   total,
  output logic                        total_zero,
  output logic                        hit
);
  import wrp_pkg::*;

  logic [EFF_W-1:0]  eff;
  logic [EFF_W-1:0]  eff_r;
  entry_t            ent_r;
  logic [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]  total_r;
  logic [SUM_W-1:0]  thr_r;
  logic [SUM_W-1:0]  run_nxt;
  logic [PROD_W-1:0] prod;

  always_comb begin
    logic [WEIGHT_W-1:0] base;
    base = cfg.use_weight ? rd_ent.weight : ONE_Q88;
    eff  = EFF_W'(base);
    if (cfg.use_pool) begin
      if (rd_ent.pool == '0) begin
        eff = '0;
      end else if (cfg.scale_by_pool) begin
        eff = EFF_W'(base) * EFF_W'(rd_ent.pool);
      end
    end
    if (rd_ent.blocked || (!cfg.allow_repeat && rd_mark)) begin
      eff = '0;
    end
  end

  assign run_nxt = acc_r + SUM_W'(eff_r);
  assign prod    = PROD_W'(rand_val) * PROD_W'(total_r);

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      eff_r <= eff;
      ent_r <= rd_ent;
    end
    if (ctl.ld_total) begin
      total_r <= acc_r;
    end
    if (ctl.acc_clr) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      acc_r <= run_nxt;
    end
    if (ctl.ld_thr) begin
      thr_r <= prod[PROD_W-1:RAND_W];
    end
  end

  // target is thr + 1, so reaching it means exceeding thr
  assign hit        = run_nxt > thr_r;
  assign stage_ent  = ent_r;
  assign total      = total_r;
  assign total_zero = total_r == '0;

endmodule

// File: rtl/weighted_random_pick_with_pools.sv
// top level: sequencer for table writes, mark clears and roulette wheel picks
//
//   channel | ports                                          | handshake
//   --------+------------------------------------------------+---------------------------
//   input   | in_action .. in_random_value                   | start high, busy low
//   result  | out_chosen, out_chosen_index, out_total_weight | out_valid, one cycle
//   config  | cfg_index, cfg_data                            | cfg_we, written at once
//
// a write, a mark clear or an unused action gives its result the cycle after start.
// a pick makes one pass of the table memory to sum weights over the n entries in use,
// then a multiply state, then a scan pass that stops at the winner.
// the table memory has a single read port; busy is high meanwhile.
// reset clears the table valid flags and marks at once, with no clearing pass.
// the receiver cannot stall: each result is shown for exactly one cycle.
module weighted_random_pick_with_pools (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [wrp_pkg::ACT_W-1:0]        in_action,
  input  logic [wrp_pkg::IN_IDX_W-1:0]     in_entry_index,
  input  logic [wrp_pkg::WEIGHT_W-1:0]     in_weight_value,
  input  logic [wrp_pkg::POOL_W-1:0]       in_pool_count,
  input  logic                             in_blocked,
  input  logic [wrp_pkg::RAND_W-1:0]       in_random_value,
  output logic                             out_valid,
  output logic                             out_chosen,
  output logic [wrp_pkg::OUT_IDX_W-1:0]    out_chosen_index,
  output logic [wrp_pkg::OUT_TOT_W-1:0]    out_total_weight,
  input  logic                             cfg_we,
  input  logic [wrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wrp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wrp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  localparam int CMP_W = (SUM_W > OUT_TOT_W) ? SUM_W : OUT_TOT_W;
  localparam logic [OUT_TOT_W-1:0] TOT_MAX = '1;

  state_t                 state_r;
  cfg_t                   cfg_r;
  logic [NUSE_W-1:0]      cfg_entries_r;
  logic [CNT_W-1:0]       n_r;
  logic [CNT_W-1:0]       iss_r;
  logic [IDX_W-1:0]       idx1_r;
  logic [IDX_W-1:0]       idx2_r;
  logic                   v1_r;
  logic                   v2_r;
  logic [RAND_W-1:0]      rand_r;
  logic                   out_valid_r;
  logic                   out_chosen_r;
  logic [OUT_IDX_W-1:0]   out_index_r;
  logic [OUT_TOT_W-1:0]   out_total_r;

  logic                   accept;
  logic                   pick_go;
  logic                   scan_hit;
  logic                   issue;
  logic                   sum_done;
  logic [CNT_W-1:0]       n_clamp;
  logic [CMP_W-1:0]       tot_ext;
  logic [OUT_TOT_W-1:0]   tot_sat;
  store_req_t             sreq;
  dp_ctl_t                dctl;
  entry_t                 rd_ent;
  logic                   rd_mark;
  entry_t                 stage_ent;
  logic [SUM_W-1:0]       total;
  logic                   total_zero;
  logic                   hit;

  assign accept   = start && (state_r == ST_IDLE);
  assign pick_go  = accept && (in_action == ACT_PICK);
  assign scan_hit = (state_r == ST_SCAN) && v2_r && hit;
  assign issue    = ((state_r == ST_SUM) || ((state_r == ST_SCAN) && !scan_hit))
                    && (iss_r < n_r);
  assign sum_done = (state_r == ST_SUM) && !issue && !v1_r && !v2_r;
  assign n_clamp  = (int'(cfg_entries_r) > ENTRIES) ? CNT_W'(ENTRIES)
                                                    : CNT_W'(cfg_entries_r);
  assign tot_ext  = CMP_W'(total);
  assign tot_sat  = (tot_ext > CMP_W'(TOT_MAX)) ? TOT_MAX : OUT_TOT_W'(tot_ext);

  always_comb begin
    sreq          = '0;
    sreq.rd_addr  = iss_r[IDX_W-1:0];
    sreq.mark_clr = accept && (in_action == ACT_CLEAR);
    if (state_r == ST_COMMIT) begin
      sreq.wr_addr      = idx2_r;
      sreq.wr_data      = stage_ent;
      sreq.wr_data.pool = stage_ent.pool - POOL_W'(1);
      sreq.wr_en        = cfg_r.use_pool && (stage_ent.pool != '0);
      sreq.mark_set     = !cfg_r.allow_repeat;
    end else begin
      sreq.wr_addr              = IDX_W'(in_entry_index);
      sreq.wr_data.weight       = in_weight_value;
      sreq.wr_data.pool         = in_pool_count;
      sreq.wr_data.blocked      = in_blocked;
      sreq.wr_en                = accept && (in_action == ACT_WRITE)
                                  && (int'(in_entry_index) < ENTRIES);
    end
  end

  always_comb begin
    dctl          = '0;
    dctl.shift    = ((state_r == ST_SUM) || (state_r == ST_SCAN)) && !scan_hit;
    dctl.acc_add  = v2_r && ((state_r == ST_SUM) || (state_r == ST_SCAN));
    dctl.ld_total = sum_done;
    dctl.acc_clr  = pick_go || sum_done;
    dctl.ld_thr   = state_r == ST_MUL;
  end

  wrp_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .rd_ent  (rd_ent),
    .rd_mark (rd_mark)
  );

  wrp_dp u_dp (
    .clk        (clk),
    .cfg        (cfg_r),
    .ctl        (dctl),
    .rd_ent     (rd_ent),
    .rd_mark    (rd_mark),
    .rand_val   (rand_r),
    .stage_ent  (stage_ent),
    .total      (total),
    .total_zero (total_zero),
    .hit        (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r             <= ST_IDLE;
      cfg_r.use_weight    <= 1'b1;
      cfg_r.use_pool      <= 1'b0;
      cfg_r.scale_by_pool <= 1'b0;
      cfg_r.allow_repeat  <= 1'b0;
      cfg_entries_r       <= NUSE_W'(64);
      iss_r               <= '0;
      v1_r                <= 1'b0;
      v2_r                <= 1'b0;
      out_valid_r         <= 1'b0;
    end else begin
      out_valid_r <= (accept && (in_action != ACT_PICK))
                     || ((state_r == ST_MUL) && total_zero)
                     || (state_r == ST_COMMIT);
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_USE_WEIGHT:    cfg_r.use_weight    <= cfg_data[0];
          REG_USE_POOL:      cfg_r.use_pool      <= cfg_data[0];
          REG_SCALE_BY_POOL: cfg_r.scale_by_pool <= cfg_data[0];
          REG_ALLOW_REPEAT:  cfg_r.allow_repeat  <= cfg_data[0];
          REG_ENTRIES:       cfg_entries_r       <= NUSE_W'(cfg_data);
          default: ;
        endcase
      end
      v1_r <= issue;
      v2_r <= dctl.shift ? v1_r : 1'b0;
      if (issue) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      if (dctl.shift) begin
        idx2_r <= idx1_r;
      end
      idx1_r <= iss_r[IDX_W-1:0];
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            rand_r <= in_random_value;
            n_r    <= n_clamp;
            iss_r  <= '0;
            if (in_action == ACT_PICK) begin
              state_r <= ST_SUM;
            end else begin
              out_chosen_r <= 1'b0;
              out_index_r  <= '0;
              out_total_r  <= '0;
            end
          end
        end
        ST_SUM: begin
          if (sum_done) begin
            iss_r   <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (total_zero) begin
            out_chosen_r <= 1'b0;
            out_index_r  <= '0;
            out_total_r  <= '0;
            state_r      <= ST_IDLE;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_hit) begin
            state_r <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          out_chosen_r <= 1'b1;
          out_index_r  <= OUT_IDX_W'(idx2_r);
          out_total_r  <= tot_sat;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy             = state_r != ST_IDLE;
  assign out_valid        = out_valid_r;
  assign out_chosen       = out_chosen_r;
  assign out_chosen_index = out_index_r;
  assign out_total_weight = out_total_r;

`ifndef NO_ASSERTIONS
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted item neither finished nor in progress");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  a_chosen_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chosen |-> out_total_weight != '0)
    else $error("pick reported with zero total");

  a_hit_commit: assert property (@(posedge clk) disable iff (!rst_n)
    scan_hit |=> state_r == ST_COMMIT && $past(idx2_r) == idx2_r)
    else $error("winner not held into commit");

  a_scan_finds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && !issue && !v1_r && !v2_r |-> 1'b0)
    else $error("scan ran out of entries without a winner");
`endif

endmodule
